@@ rtl/core/fwir_pkg.sv @@
// package for the queue with indexed removal
// holds field widths, operation and error codes, sequencer states and control structs
// no dependencies
package fwir_pkg;

   // default queue depth
   localparam int DEPTH_DEF = 16;

   // field widths
   localparam int DATA_W  = 32;
   localparam int OP_W    = 2;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;
   localparam int ERR_W   = 2;

   // packed bus widths, padded to whole bytes
   localparam int REQ_W = 40;
   localparam int RSP_W = 40;

   // request operations
   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_REMOVE  = 2'd2
   } op_type;

   // result error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2,
      ERR_RANGE = 2'd3
   } err_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_HEAD_RD,
      ST_HEAD_OUT
   } state_type;

   // storage port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // result status from sequencer
   typedef struct packed {
      logic    res_valid;
      err_type err;
   } res_stat_type;

endpackage

@@ rtl/core/fwir_mem.sv @@
// element storage for the queue: one write port, one registered read port
// depends on fwir_pkg
module fwir_mem #(
   parameter int DEPTH = fwir_pkg::DEPTH_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                              clock,
   input  fwir_pkg::mem_ctl_type             ctl,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [fwir_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]                     rd_addr,
   output logic signed [fwir_pkg::DATA_W-1:0] rd_data
);

   logic signed [fwir_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [fwir_pkg::DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fwir_seq.sv @@
// sequencer for the queue: decodes requests, keeps the entry count and
// walks the storage one entry per cycle to close the gap on removal
// depends on fwir_pkg
module fwir_seq #(
   parameter int DEPTH = fwir_pkg::DEPTH_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fwir_pkg::op_type                   req_op,
   input  logic signed [fwir_pkg::DATA_W-1:0] req_value,
   input  logic [fwir_pkg::POS_W-1:0]         req_pos,
   input  logic                               res_ready,
   output fwir_pkg::res_stat_type             stat,
   output logic [CW-1:0]                      count,
   output fwir_pkg::mem_ctl_type              mem_ctl,
   output logic [AW-1:0]                      wr_addr,
   output logic signed [fwir_pkg::DATA_W-1:0] wr_data,
   output logic [AW-1:0]                      rd_addr,
   input  logic signed [fwir_pkg::DATA_W-1:0] rd_data
);

   // compare width wide enough for both position and count
   localparam int XW = (CW > fwir_pkg::POS_W) ? CW : fwir_pkg::POS_W;

   fwir_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   fwir_pkg::err_type   err_ff, err_in;

   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       count_x;
   logic [XW-1:0]       idx_x;
   logic                shift_start;
   logic                accept;

   assign pos_x   = XW'(req_pos);
   assign count_x = XW'(count_ff);
   assign accept  = req_valid && (state_ff == fwir_pkg::ST_IDLE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fwir_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // walk pointers and latched error
   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      wr_addr_ff <= wr_addr_in;
      err_ff     <= err_in;
   end

   // next state and storage control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      pend_in     = pend_ff;
      wr_addr_in  = wr_addr_ff;
      err_in      = err_ff;
      mem_ctl     = '0;
      wr_addr     = wr_addr_ff;
      wr_data     = rd_data;
      rd_addr     = rd_ptr_ff[AW-1:0];
      shift_start = 1'b0;
      idx_x       = '0;
      stat        = '0;
      stat.err    = err_ff;

      case (state_ff)
         fwir_pkg::ST_IDLE: begin
            if (accept) begin
               err_in   = fwir_pkg::ERR_NONE;
               state_in = fwir_pkg::ST_HEAD_RD;
               case (req_op)
                  fwir_pkg::OP_ENQUEUE: begin
                     if (count_ff == CW'(DEPTH)) begin
                        err_in = fwir_pkg::ERR_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = count_ff[AW-1:0];
                        wr_data       = req_value;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  fwir_pkg::OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        err_in = fwir_pkg::ERR_EMPTY;
                     end else begin
                        shift_start = 1'b1;
                     end
                  end
                  fwir_pkg::OP_REMOVE: begin
                     if (pos_x >= count_x) begin
                        err_in = fwir_pkg::ERR_RANGE;
                     end else begin
                        shift_start = 1'b1;
                        idx_x       = pos_x;
                     end
                  end
                  default: begin
                  end
               endcase
               // start the gap-closing walk just after the removed entry
               if (shift_start) begin
                  rd_ptr_in = CW'(idx_x + XW'(1));
                  pend_in   = 1'b0;
                  state_in  = fwir_pkg::ST_SHIFT;
               end
            end
         end

         fwir_pkg::ST_SHIFT: begin
            // write back the entry read last cycle one place lower
            mem_ctl.wr_en = pend_ff;
            if (rd_ptr_ff < count_ff) begin
               mem_ctl.rd_en = 1'b1;
               pend_in       = 1'b1;
               wr_addr_in    = rd_ptr_ff[AW-1:0] - AW'(1);
               rd_ptr_in     = rd_ptr_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = fwir_pkg::ST_HEAD_RD;
               end
            end
         end

         fwir_pkg::ST_HEAD_RD: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = '0;
            state_in      = fwir_pkg::ST_HEAD_OUT;
         end

         fwir_pkg::ST_HEAD_OUT: begin
            stat.res_valid = 1'b1;
            if (res_ready) begin
               state_in = fwir_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fwir_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == fwir_pkg::ST_IDLE);
   assign count     = count_ff;

endmodule

@@ rtl/core/fifo_with_indexed_removal_top.sv @@
// queue with indexed removal: enqueue, dequeue, or remove at a position.
// enqueue, error or unused code: the head is read, then the result goes to the result register;
// dequeue or removal at position p with n entries: the walk first moves entries p+1 to n-1 down
// one place, one entry per cycle through the storage port, then the head is read and returned.
// one request at a time: no new request is taken until the result register has taken the result.
// reset clears the count and handshake state; storage is not cleared.
module fifo_with_indexed_removal_top #(
   parameter int DEPTH = fwir_pkg::DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // operation[1:0], value[33:2], position[37:34], zero pad[39:38]
   input  logic [fwir_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // head_value[31:0], count[36:32], is_empty[37], error[39:38]
   output logic [fwir_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fwir_pkg::op_type                   req_op;
   logic signed [fwir_pkg::DATA_W-1:0] req_value;
   logic [fwir_pkg::POS_W-1:0]         req_pos;

   fwir_pkg::res_stat_type             stat;
   fwir_pkg::mem_ctl_type              mem_ctl;
   logic [CW-1:0]                      count;
   logic [AW-1:0]                      wr_addr;
   logic [AW-1:0]                      rd_addr;
   logic signed [fwir_pkg::DATA_W-1:0] wr_data;
   logic signed [fwir_pkg::DATA_W-1:0] rd_data;

   logic                               res_ready;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [fwir_pkg::RSP_W-1:0]         rsp_tdata_ff, rsp_tdata_in;
   logic signed [fwir_pkg::DATA_W-1:0] head;
   logic                               empty;

   // unpack request fields
   assign req_op    = fwir_pkg::op_type'(req_tdata[1:0]);
   assign req_value = req_tdata[33:2];
   assign req_pos   = req_tdata[37:34];

   fwir_seq #(
      .DEPTH(DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_op),
      .req_value (req_value),
      .req_pos   (req_pos),
      .res_ready (res_ready),
      .stat      (stat),
      .count     (count),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   fwir_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result formatting
   assign empty     = (count == '0);
   assign head      = empty ? '0 : rd_data;
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   // output register load and drain
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (stat.res_valid && res_ready) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {stat.err, empty, fwir_pkg::COUNT_W'(count), head};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
